[rtl/unicode_code_point_transcoder_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the transcoder
// Implication checks, sampled on the rising clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef UNICODE_CODE_POINT_TRANSCODER_TOP_ASSERT_SVH
`define UNICODE_CODE_POINT_TRANSCODER_TOP_ASSERT_SVH

// same-cycle implication
`define UTC_ASSERT_SAME(label, clock, resetn, cond, check, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) \
        (cond) |-> (check)) else $error(msg);

// next-cycle implication
`define UTC_ASSERT_NEXT(label, clock, resetn, cond, check, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) \
        (cond) |=> (check)) else $error(msg);

`endif

[rtl/utc_pkg.sv]
// ----------------------------------------------------------------------------
// utc_pkg
// Shared types and codes of the code point transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utc_pkg;

    localparam int MODE_W      = 2;
    localparam int CP_W        = 21;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 96;

    localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UTF8   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UTF16  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CP_W-1:0]   code_point;
        logic [7:0]        byte0;
        logic [7:0]        byte1;
        logic [7:0]        byte2;
        logic [7:0]        byte3;
        logic [15:0]       half0;
        logic [15:0]       half1;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0] scalar;
        logic [2:0]      consumed;
        logic [7:0]      out8_0;
        logic [7:0]      out8_1;
        logic [7:0]      out8_2;
        logic [7:0]      out8_3;
        logic [2:0]      out8_count;
        logic [15:0]     out16_0;
        logic [15:0]     out16_1;
        logic [1:0]      out16_count;
    } out_item_t;

endpackage

`default_nettype wire

[rtl/unicode_code_point_transcoder_top.sv]
// m_axis_tvalid rises once an accepted item has passed the input register and then the result register.
// Throughput: one item per cycle while m_axis_tready is high, set by the two-stage register pipeline.
// s_axis_tready follows m_axis_tready combinationally through both stages.
// Reset: rst_n clears both stage valid flags; no item is held after reset.
// ----------------------------------------------------------------------------
// unicode_code_point_transcoder_top
// Streaming character transcoder between UTF-32, UTF-8 and UTF-16.
// ----------------------------------------------------------------------------
`default_nettype none

module unicode_code_point_transcoder_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // code_point[20:0], byte0..byte3[52:21], half0[68:53], half1[84:69], zero pad
    input  logic [utc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // mode[1:0]
    input  logic [utc_pkg::MODE_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // scalar[20:0], consumed[23:21], out8_0..out8_3[55:24], out8_count[58:56],
    // out16_0[74:59], out16_1[90:75], out16_count[92:91], zero pad
    output logic [utc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    utc_pkg::in_item_t  in_item_reg;
    utc_pkg::out_item_t res_reg;
    utc_pkg::out_item_t res_next;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_adv;
    logic               in_acc;

    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
        out_valid_next = out_adv ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_item_reg.mode       <= s_axis_tuser;
            in_item_reg.code_point <= s_axis_tdata[20:0];
            in_item_reg.byte0      <= s_axis_tdata[28:21];
            in_item_reg.byte1      <= s_axis_tdata[36:29];
            in_item_reg.byte2      <= s_axis_tdata[44:37];
            in_item_reg.byte3      <= s_axis_tdata[52:45];
            in_item_reg.half0      <= s_axis_tdata[68:53];
            in_item_reg.half1      <= s_axis_tdata[84:69];
        end
        if (out_adv && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    utc_codec u_codec
    (
        .item   (in_item_reg),
        .result (res_next)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            res_reg.out16_count,
                            res_reg.out16_1,
                            res_reg.out16_0,
                            res_reg.out8_count,
                            res_reg.out8_3,
                            res_reg.out8_2,
                            res_reg.out8_1,
                            res_reg.out8_0,
                            res_reg.consumed,
                            res_reg.scalar};

`include "unicode_code_point_transcoder_top_assert.svh"

    `UTC_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !out_adv, in_valid_reg,
        "input stage dropped an item under stall")
    `UTC_ASSERT_NEXT(a_in_load, clk, rst_n, in_acc, in_valid_reg,
        "accepted item not held in input stage")
    `UTC_ASSERT_NEXT(a_move, clk, rst_n, in_valid_reg && out_adv, out_valid_reg,
        "item did not reach result register")
    `UTC_ASSERT_SAME(a_invalid_zero, clk, rst_n,
        out_valid_reg && res_reg.consumed == 3'd0,
        res_reg.scalar == '0 && res_reg.out8_count == 3'd0 && res_reg.out16_count == 2'd0,
        "invalid sequence result not all zero")
    `UTC_ASSERT_SAME(a_valid_units, clk, rst_n,
        out_valid_reg && res_reg.consumed != 3'd0,
        res_reg.out8_count != 3'd0 && res_reg.out16_count != 2'd0,
        "decoded result without output units")

endmodule

`default_nettype wire

[rtl/utc_codec.sv]
// ----------------------------------------------------------------------------
// utc_codec
// Combinational UTF-8 / UTF-16 / UTF-32 conversion of one character.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_codec
(
    input  utc_pkg::in_item_t  item,
    output utc_pkg::out_item_t result
);

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [2:0] count;
    } utf8_enc_t;

    typedef struct packed {
        logic [15:0] u0;
        logic [15:0] u1;
        logic [1:0]  count;
    } utf16_enc_t;

    function automatic utf8_enc_t enc_utf8(input logic [utc_pkg::CP_W-1:0] cp);
        utf8_enc_t e;
        e = '0;
        if (cp > 21'h00FFFF)
        begin
            e.b0    = {5'b11110, cp[20:18]};
            e.b1    = {2'b10, cp[17:12]};
            e.b2    = {2'b10, cp[11:6]};
            e.b3    = {2'b10, cp[5:0]};
            e.count = 3'd4;
        end
        else if (cp > 21'h0007FF)
        begin
            e.b0    = {4'b1110, cp[15:12]};
            e.b1    = {2'b10, cp[11:6]};
            e.b2    = {2'b10, cp[5:0]};
            e.count = 3'd3;
        end
        else if (cp > 21'h00007F)
        begin
            e.b0    = {3'b110, cp[10:6]};
            e.b1    = {2'b10, cp[5:0]};
            e.count = 3'd2;
        end
        else
        begin
            e.b0    = {1'b0, cp[6:0]};
            e.count = 3'd1;
        end
        return e;
    endfunction

    function automatic utf16_enc_t enc_utf16(input logic [utc_pkg::CP_W-1:0] cp);
        utf16_enc_t              e;
        logic [utc_pkg::CP_W-1:0] v;
        e = '0;
        v = cp - 21'h010000;
        if (cp > 21'h00FFFF)
        begin
            e.u0    = 16'hD800 + {5'b0, v[20:10]};
            e.u1    = 16'hDC00 + {6'b0, v[9:0]};
            e.count = 2'd2;
        end
        else
        begin
            e.u0    = cp[15:0];
            e.count = 2'd1;
        end
        return e;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    utf8_enc_t                e8;
    utf16_enc_t               e16;
    logic [utc_pkg::CP_W-1:0] s;
    logic [2:0]               n;

    always_comb
    begin
        result = '0;
        s      = '0;
        n      = 3'd0;
        e8     = '0;
        e16    = '0;
        case (item.mode)
            utc_pkg::MODE_ENCODE:
            begin
                e8                 = enc_utf8(item.code_point);
                e16                = enc_utf16(item.code_point);
                result.scalar      = item.code_point;
                result.consumed    = 3'd1;
                result.out8_0      = e8.b0;
                result.out8_1      = e8.b1;
                result.out8_2      = e8.b2;
                result.out8_3      = e8.b3;
                result.out8_count  = e8.count;
                result.out16_0     = e16.u0;
                result.out16_1     = e16.u1;
                result.out16_count = e16.count;
            end
            utc_pkg::MODE_UTF8:
            begin
                if (item.byte0[7:3] == 5'b11110)
                begin
                    if (is_cont(item.byte1) && is_cont(item.byte2) && is_cont(item.byte3))
                    begin
                        s = {item.byte0[2:0], item.byte1[5:0], item.byte2[5:0],
                             item.byte3[5:0]};
                        n = 3'd4;
                    end
                end
                else if (item.byte0[7:4] == 4'b1110)
                begin
                    if (is_cont(item.byte1) && is_cont(item.byte2))
                    begin
                        s = {5'b0, item.byte0[3:0], item.byte1[5:0], item.byte2[5:0]};
                        n = 3'd3;
                    end
                end
                else if (item.byte0[7:5] == 3'b110)
                begin
                    if (is_cont(item.byte1))
                    begin
                        s = {10'b0, item.byte0[4:0], item.byte1[5:0]};
                        n = 3'd2;
                    end
                end
                else
                begin
                    s = {13'b0, item.byte0};
                    n = 3'd1;
                end
                if (n != 3'd0)
                begin
                    e16                = enc_utf16(s);
                    result.scalar      = s;
                    result.consumed    = n;
                    result.out8_0      = item.byte0;
                    result.out8_1      = (n > 3'd1) ? item.byte1 : 8'h00;
                    result.out8_2      = (n > 3'd2) ? item.byte2 : 8'h00;
                    result.out8_3      = (n > 3'd3) ? item.byte3 : 8'h00;
                    result.out8_count  = n;
                    result.out16_0     = e16.u0;
                    result.out16_1     = e16.u1;
                    result.out16_count = e16.count;
                end
            end
            utc_pkg::MODE_UTF16:
            begin
                if (item.half0[15:10] == 6'b110110)
                begin
                    if (item.half1[15:10] == 6'b110111)
                    begin
                        s = {1'b0, item.half0[9:0], item.half1[9:0]} + 21'h010000;
                        n = 3'd2;
                    end
                end
                else
                begin
                    s = {5'b0, item.half0};
                    n = 3'd1;
                end
                if (n != 3'd0)
                begin
                    e8                 = enc_utf8(s);
                    e16                = enc_utf16(s);
                    result.scalar      = s;
                    result.consumed    = n;
                    result.out8_0      = e8.b0;
                    result.out8_1      = e8.b1;
                    result.out8_2      = e8.b2;
                    result.out8_3      = e8.b3;
                    result.out8_count  = e8.count;
                    result.out16_0     = e16.u0;
                    result.out16_1     = e16.u1;
                    result.out16_count = e16.count;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

`default_nettype wire
